@@ hw/rtl/pic_pkg.sv @@
// Package for the priority interrupt controller: command and result types,
// action codes, internal request structs and shared helper functions.
// Has no dependencies; every other file of the block uses it.
`default_nettype none

package pic_pkg;

  localparam int unsigned NumLines  = 4;
  localparam int unsigned NumLevels = 32;
  localparam int unsigned VecPerLvl = 8;

  localparam logic [31:0] LineVectorsRst = 32'hff00_0000;
  localparam logic [4:0]  TopLevel       = 5'd31;

  typedef enum logic [1:0] {
    ACT_LINE = 2'd0,
    ACT_IMM  = 2'd1,
    ACT_PEND = 2'd2
  } action_e;

  typedef struct packed {
    action_e    action;
    logic [1:0] line;
    logic       line_level;
    logic [4:0] cpu_priority;
  } cmd_t;

  typedef struct packed {
    logic       taken;
    logic [7:0] vector;
    logic [4:0] level;
    logic       acknowledged;
    logic       unsupported_line;
    logic       missing_vector;
  } result_t;

  // Request to post one vector into the pending tables.
  typedef struct packed {
    logic       en;
    logic [7:0] vec;
  } post_t;

  // Outcome of a pending-table check.
  typedef struct packed {
    logic       hit;
    logic       missing;
    logic [4:0] lvl;
    logic [2:0] idx;
  } pick_t;

  // A level wins over the processor priority when it is strictly higher,
  // and the top level always wins.
  function automatic logic beats(logic [4:0] lvl, logic [4:0] cpu_pri);
    return (cpu_pri < lvl) || (lvl == TopLevel);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pic_pend_table.sv @@
// Pending tables: one bit per priority level and one byte of vector bits
// per level, with the highest-eligible-level search. Depends on pic_pkg.
`default_nettype none

module pic_pend_table (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pic_pkg::post_t post_i,
  input  logic           chk_en_i,
  input  logic [4:0]     cpu_pri_i,
  output pic_pkg::pick_t pick_o
);

  logic [31:0] pend_q, pend_d;
  logic [7:0]  vec_q [32];

  logic [31:0] elig;
  logic        any_elig;
  logic [4:0]  sel_lvl;
  logic [7:0]  sel_byte;
  logic [7:0]  cleared_byte;
  logic        any_bit;
  logic [2:0]  sel_idx;
  logic [4:0]  post_lvl;

  always_comb begin
    for (int l = 0; l < 32; l++) begin
      elig[l] = pend_q[l] & pic_pkg::beats(5'(l), cpu_pri_i);
    end
  end

  // Highest set bit wins.
  always_comb begin
    sel_lvl = '0;
    for (int l = 0; l < 32; l++) begin
      if (elig[l]) begin
        sel_lvl = 5'(l);
      end
    end
  end

  assign any_elig = |elig;
  assign sel_byte = vec_q[sel_lvl];
  assign any_bit  = |sel_byte;

  always_comb begin
    sel_idx = '0;
    for (int b = 0; b < 8; b++) begin
      if (sel_byte[b]) begin
        sel_idx = 3'(b);
      end
    end
  end

  always_comb begin
    cleared_byte          = sel_byte;
    cleared_byte[sel_idx] = 1'b0;
  end

  assign post_lvl = post_i.vec[7:3];

  always_comb begin
    pend_d = pend_q;
    if (chk_en_i && any_elig) begin
      if (!any_bit || (cleared_byte == '0)) begin
        pend_d[sel_lvl] = 1'b0;
      end
    end
    if (post_i.en) begin
      pend_d[post_lvl] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < 32; l++) begin
        vec_q[l] <= '0;
      end
    end else begin
      if (chk_en_i && any_elig && any_bit) begin
        vec_q[sel_lvl] <= cleared_byte;
      end
      if (post_i.en) begin
        vec_q[post_lvl][post_i.vec[2:0]] <= 1'b1;
      end
    end
  end

  assign pick_o.hit     = chk_en_i & any_elig & any_bit;
  assign pick_o.missing = chk_en_i & any_elig & ~any_bit;
  assign pick_o.lvl     = sel_lvl;
  assign pick_o.idx     = sel_idx;

  // A dispatched vector was pending at a level that was marked pending.
  a_hit_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pick_o.hit |-> (pend_q[pick_o.lvl] && sel_byte[pick_o.idx]))
    else $error("pending pick on a level that is not pending");

  // A posted vector is visible in both tables on the next cycle.
  a_post_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    post_i.en |=> (pend_q[$past(post_i.vec[7:3])]
                   && vec_q[$past(post_i.vec[7:3])][$past(post_i.vec[2:0])]))
    else $error("posted vector missing from pending tables");

endmodule

`default_nettype wire

@@ hw/rtl/pic_line_ctrl.sv @@
// Line state tracking, immediate interrupt latch and result assembly for
// one command. Depends on pic_pkg; drives the pending table requests.
`default_nettype none

module pic_line_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             vld_i,
  input  pic_pkg::cmd_t    cmd_i,
  input  logic [31:0]      line_vectors_i,
  input  pic_pkg::pick_t   pick_i,
  output pic_pkg::post_t   post_o,
  output logic             chk_en_o,
  output pic_pkg::result_t res_o
);

  logic [3:0] line_state_q, line_state_d;
  logic       imm_valid_q, imm_valid_d;
  logic [7:0] imm_vec_q, imm_vec_d;
  logic [4:0] imm_lvl_q, imm_lvl_d;

  logic [7:0] line_vec;
  logic [4:0] line_pri;

  assign line_vec = line_vectors_i[{cmd_i.line, 3'b000} +: 8];
  assign line_pri = line_vec[7:3];

  // The pending search is requested from the command alone, so the pick that
  // comes back never feeds into this request.
  assign chk_en_o = vld_i && (cmd_i.action == pic_pkg::ACT_PEND);

  always_comb begin
    line_state_d = line_state_q;
    imm_valid_d  = imm_valid_q;
    imm_vec_d    = imm_vec_q;
    imm_lvl_d    = imm_lvl_q;
    post_o       = '0;
    res_o        = '0;
    if (vld_i) begin
      case (cmd_i.action)
        pic_pkg::ACT_LINE: begin
          if (line_state_q[cmd_i.line] != cmd_i.line_level) begin
            line_state_d[cmd_i.line] = cmd_i.line_level;
            if (line_vec == '0) begin
              res_o.unsupported_line = 1'b1;
            end else if (cmd_i.line_level) begin
              if (pic_pkg::beats(line_pri, cmd_i.cpu_priority) && !imm_valid_q) begin
                imm_valid_d = 1'b1;
                imm_vec_d   = line_vec;
                imm_lvl_d   = line_pri;
              end else begin
                post_o.en  = 1'b1;
                post_o.vec = line_vec;
              end
              res_o.acknowledged = 1'b1;
            end
          end
        end
        pic_pkg::ACT_IMM: begin
          if (imm_valid_q && pic_pkg::beats(imm_lvl_q, cmd_i.cpu_priority)) begin
            res_o.taken  = 1'b1;
            res_o.vector = imm_vec_q;
            res_o.level  = imm_lvl_q;
            imm_valid_d  = 1'b0;
          end
        end
        pic_pkg::ACT_PEND: begin
          res_o.missing_vector = pick_i.missing;
          if (pick_i.hit) begin
            res_o.taken  = 1'b1;
            res_o.vector = {pick_i.lvl, pick_i.idx};
            res_o.level  = pick_i.lvl;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_state_q <= '0;
      imm_valid_q  <= 1'b0;
      imm_vec_q    <= '0;
      imm_lvl_q    <= '0;
    end else begin
      line_state_q <= line_state_d;
      imm_valid_q  <= imm_valid_d;
      imm_vec_q    <= imm_vec_d;
      imm_lvl_q    <= imm_lvl_d;
    end
  end

  // Dispatching the immediate interrupt empties the latch.
  a_imm_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_i && cmd_i.action == pic_pkg::ACT_IMM && res_o.taken) |=> !imm_valid_q)
    else $error("immediate latch still set after dispatch");

  // A held immediate interrupt is never overwritten.
  a_imm_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (imm_valid_q && !(vld_i && cmd_i.action == pic_pkg::ACT_IMM))
      |=> (imm_valid_q && $stable(imm_vec_q) && $stable(imm_lvl_q)))
    else $error("held immediate interrupt changed");

endmodule

`default_nettype wire

@@ hw/rtl/priority_interrupt_controller_top.sv @@
// Flow: a command accepted at a clock edge is captured in the input register,
// evaluated from there, and its result is registered onto res_o with done_o.
// Throughput: one command per cycle; busy never rises, and the evaluation
// is one pass of a 32-level and an 8-bit priority encoder.
// Reset clears line states, pending tables and the immediate latch, and loads
// line_vectors with its reset value; the receiver cannot stall results.
`default_nettype none

module priority_interrupt_controller_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  pic_pkg::cmd_t    cmd_i,
  output logic             done_o,
  output pic_pkg::result_t res_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [31:0]      cfg_data_i
);

  // Every command finishes in a single pass, so the block is always able to
  // take another one, and configuration writes are always taken.
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Configuration register: four 8-bit vectors, line 0 in the low byte.
  logic [31:0] line_vectors_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_vectors_q <= pic_pkg::LineVectorsRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      line_vectors_q <= cfg_data_i;
    end
  end

  // Input register: captures the command on each transfer.
  logic          vld_q;
  pic_pkg::cmd_t cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      cmd_q <= cmd_i;
    end
  end

  // Command evaluation. The line controller owns the line states and the
  // immediate latch; the pending table owns the level and vector bitmaps and
  // searches them when the controller asks for a pending check.
  pic_pkg::post_t   post;
  pic_pkg::pick_t   pick;
  pic_pkg::result_t res_d;
  logic             chk_en;

  pic_line_ctrl u_line_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .vld_i          (vld_q),
    .cmd_i          (cmd_q),
    .line_vectors_i (line_vectors_q),
    .pick_i         (pick),
    .post_o         (post),
    .chk_en_o       (chk_en),
    .res_o          (res_d)
  );

  pic_pend_table u_pend_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .post_i    (post),
    .chk_en_i  (chk_en),
    .cpu_pri_i (cmd_q.cpu_priority),
    .pick_o    (pick)
  );

  // Result register: each evaluated command yields exactly one result, shown
  // for one cycle with done_o.
  logic             done_q;
  pic_pkg::result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // A result strobe follows each command transfer through the input and result registers.
  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 done_o)
    else $error("result strobe missing after command transfer");

  // No result reports a dispatch together with a line acknowledge or a missing vector.
  a_result_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(res_o.taken && (res_o.acknowledged || res_o.missing_vector)))
    else $error("result mixes dispatch with another outcome");

endmodule

`default_nettype wire

@@ tb/pic_checker.sv @@
// Checker for the priority interrupt controller. It snoops the command, result and
// line_vectors channels, predicts every result and compares it field by field.
// Depends on pic_pkg for the command and result types and the action codes.
module pic_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  pic_pkg::cmd_t    cmd_i,
  input  logic             done_i,
  input  pic_pkg::result_t res_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [31:0]      cfg_data_i,
  input  logic             drain_i,
  output int unsigned      error_count_o,
  output int unsigned      backlog_o,
  output int unsigned      checked_o,
  output int unsigned      dispatched_o
);

  // Shadow copy of the controller state.
  logic [31:0]  vector_map;
  logic [3:0]   line_seen;
  logic [31:0]  level_mask;
  logic [255:0] vector_bits;
  logic         held_valid;
  logic [7:0]   held_vector;
  logic [4:0]   held_level;

  pic_pkg::result_t awaited_results[$];
  int unsigned      errors = 0;
  int unsigned      checked;
  int unsigned      dispatched;
  logic             drained;

  function automatic logic outranks(input logic [4:0] lvl, input logic [4:0] pri);
    return (pri < lvl) || (lvl == pic_pkg::TopLevel);
  endfunction

  task automatic evaluate_command(input pic_pkg::cmd_t c, output pic_pkg::result_t r);
    logic [7:0] vec;
    logic [4:0] lv;
    logic [7:0] group;
    logic       picked;
    int         found;
    r = '0;
    case (c.action)
      pic_pkg::ACT_LINE: begin
        if (line_seen[c.line] != c.line_level) begin
          line_seen[c.line] = c.line_level;
          vec = vector_map[{c.line, 3'b000} +: 8];
          if (vec == 8'h00) begin
            r.unsupported_line = 1'b1;
          end else if (c.line_level) begin
            lv = vec[7:3];
            if (outranks(lv, c.cpu_priority) && !held_valid) begin
              held_valid  = 1'b1;
              held_vector = vec;
              held_level  = lv;
            end else begin
              level_mask[lv]   = 1'b1;
              vector_bits[vec] = 1'b1;
            end
            r.acknowledged = 1'b1;
          end
        end
      end
      pic_pkg::ACT_IMM: begin
        if (held_valid && outranks(held_level, c.cpu_priority)) begin
          r.taken    = 1'b1;
          r.vector   = held_vector;
          r.level    = held_level;
          held_valid = 1'b0;
        end
      end
      pic_pkg::ACT_PEND: begin
        picked = 1'b0;
        for (int l = 31; l >= 0; l--) begin
          lv = 5'(l);
          if (!picked && level_mask[lv] && outranks(lv, c.cpu_priority)) begin
            picked = 1'b1;
            group  = vector_bits[{lv, 3'b000} +: 8];
            found  = -1;
            for (int b = 7; b >= 0; b--) begin
              if (found < 0 && group[b]) found = b;
            end
            if (found < 0) begin
              level_mask[lv]   = 1'b0;
              r.missing_vector = 1'b1;
            end else begin
              vec = {lv, 3'(found)};
              vector_bits[vec] = 1'b0;
              if (vector_bits[{lv, 3'b000} +: 8] == 8'h00) level_mask[lv] = 1'b0;
              r.taken  = 1'b1;
              r.vector = vec;
              r.level  = lv;
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors = errors + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : snoop
    pic_pkg::result_t want;
    pic_pkg::result_t fresh;
    if (!rst_ni) begin
      vector_map  = pic_pkg::LineVectorsRst;
      line_seen   = '0;
      level_mask  = '0;
      vector_bits = '0;
      held_valid  = 1'b0;
      held_vector = '0;
      held_level  = '0;
      checked     = 0;
      dispatched  = 0;
      drained     = 1'b0;
      awaited_results.delete();
    end else begin
      // Results are checked before this edge's command is predicted, since a
      // result always belongs to an earlier command.
      if (done_i) begin
        if (awaited_results.size() == 0) begin
          $error("result %h arrived with no command awaiting it", res_i);
          errors = errors + 1;
        end else begin
          want = awaited_results.pop_front();
          compare_field("taken", want.taken, res_i.taken);
          compare_field("vector", want.vector, res_i.vector);
          compare_field("level", want.level, res_i.level);
          compare_field("acknowledged", want.acknowledged, res_i.acknowledged);
          compare_field("unsupported_line", want.unsupported_line, res_i.unsupported_line);
          compare_field("missing_vector", want.missing_vector, res_i.missing_vector);
          checked = checked + 1;
          if (want.taken) dispatched = dispatched + 1;
        end
      end
      if (cfg_valid_i && cfg_ready_i) vector_map = cfg_data_i;
      if (start_i && !busy_i) begin
        evaluate_command(cmd_i, fresh);
        awaited_results.push_back(fresh);
      end
      if (drain_i && !drained) begin
        drained = 1'b1;
        if (awaited_results.size() != 0) begin
          $error("%0d expected results never arrived", awaited_results.size());
          errors = errors + awaited_results.size();
        end
      end
    end
    error_count_o <= errors;
    backlog_o     <= awaited_results.size();
    checked_o     <= checked;
    dispatched_o  <= dispatched;
  end

endmodule

@@ tb/testbench.sv @@
// Top of the priority interrupt controller testbench: clock, reset, directed and
// random command stimulus, line_vectors writes and the final verdict.
// Depends on pic_pkg, priority_interrupt_controller_top and pic_checker.
module testbench;

  // The action encoding leaves one code unused; the block must treat it as a no-op.
  localparam logic [1:0]  ActUndefined = 2'd3;
  localparam int unsigned RandomPhases = 8;
  localparam int unsigned PhaseItems   = 100;

  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             start     = 1'b0;
  logic             busy;
  pic_pkg::cmd_t    cmd       = '0;
  logic             done;
  pic_pkg::result_t res;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [31:0]      cfg_data  = '0;
  logic             drain     = 1'b0;

  int unsigned error_count;
  int unsigned backlog;
  int unsigned checked;
  int unsigned dispatched;

  // Last level driven on each external line. The random part uses it to make
  // most line changes real toggles, since repeats of the same level do nothing.
  logic [3:0]  line_shadow   = '0;
  int unsigned commands_sent = 0;
  int unsigned settings_used = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  priority_interrupt_controller_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd),
    .done_o     (done),
    .res_o      (res),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  // The checker sits beside the block and sees exactly what the block sees.
  pic_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .cmd_i        (cmd),
    .done_i       (done),
    .res_i        (res),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .drain_i      (drain),
    .error_count_o(error_count),
    .backlog_o    (backlog),
    .checked_o    (checked),
    .dispatched_o (dispatched)
  );

  function automatic pic_pkg::cmd_t make_cmd(input logic [1:0] act, input logic [1:0] ln,
                                             input logic lvl, input logic [4:0] pri);
    pic_pkg::cmd_t c;
    c.action       = pic_pkg::action_e'(act);
    c.line         = ln;
    c.line_level   = lvl;
    c.cpu_priority = pri;
    return c;
  endfunction

  // Half of the random commands are line changes, the rest mostly checks of
  // the latch and the pending tables, with a few undefined actions as noise.
  // The processor priority leans toward both ends so that the top level and
  // the never-eligible level zero show up often.
  function automatic pic_pkg::cmd_t random_command();
    int unsigned roll;
    logic [1:0]  act;
    logic [1:0]  ln;
    logic        lvl;
    logic [4:0]  pri;
    roll = $urandom_range(0, 99);
    if (roll < 50) act = pic_pkg::ACT_LINE;
    else if (roll < 70) act = pic_pkg::ACT_IMM;
    else if (roll < 96) act = pic_pkg::ACT_PEND;
    else act = ActUndefined;
    ln   = 2'($urandom_range(0, 3));
    lvl  = ($urandom_range(0, 9) < 8) ? !line_shadow[ln] : line_shadow[ln];
    roll = $urandom_range(0, 3);
    if (roll == 0) pri = 5'd0;
    else if (roll == 1) pri = pic_pkg::TopLevel;
    else pri = 5'($urandom_range(0, 31));
    return make_cmd(act, ln, lvl, pri);
  endfunction

  // Random line_vectors word; about one byte in eight is zero so that
  // unsupported lines keep turning up.
  function automatic logic [31:0] random_vectors();
    logic [31:0] word;
    for (int i = 0; i < 4; i++) begin
      if ($urandom_range(0, 7) == 0) word[i*8 +: 8] = 8'h00;
      else word[i*8 +: 8] = 8'($urandom_range(1, 255));
    end
    return word;
  endfunction

  // Called at a rising edge. Start stays high from one transfer to the next
  // when commands follow back to back, so it gets one assignment per step.
  task automatic issue_command(input pic_pkg::cmd_t c);
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk_i); while (busy);
    commands_sent = commands_sent + 1;
    if (c.action == pic_pkg::ACT_LINE) line_shadow[c.line] = c.line_level;
  endtask

  task automatic pause(input int unsigned cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Every command yields exactly one result, so the block is idle once the
  // checker holds no expectation. The first edge lets the last transfer reach
  // the checker's count.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (backlog != 0) @(posedge clk_i);
  endtask

  task automatic write_line_vectors(input logic [31:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings_used = settings_used + 1;
  endtask

  initial begin : stimulus
    int unsigned burst;
    int unsigned sent;
    logic [31:0] setting;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset setting: lines 0 to 2 carry vector zero,
    // line 3 carries vector 255 at the top level.
    issue_command(make_cmd(pic_pkg::ACT_LINE, 2'd0, 1'b1, 5'd0)); // unsupported line
    issue_command(make_cmd(pic_pkg::ACT_LINE, 2'd0, 1'b1, 5'd0)); // unchanged line
    issue_command(make_cmd(pic_pkg::ACT_LINE, 2'd0, 1'b0, 5'd0));
    // The top level always latches.
    issue_command(make_cmd(pic_pkg::ACT_LINE, 2'd3, 1'b1, pic_pkg::TopLevel));
    issue_command(make_cmd(pic_pkg::ACT_LINE, 2'd3, 1'b0, 5'd0)); // deassertion
    // The latch is busy, so this one is posted.
    issue_command(make_cmd(pic_pkg::ACT_LINE, 2'd3, 1'b1, 5'd0));
    issue_command(make_cmd(pic_pkg::ACT_IMM, 2'd0, 1'b0, pic_pkg::TopLevel));
    issue_command(make_cmd(pic_pkg::ACT_IMM, 2'd0, 1'b0, 5'd0));  // nothing latched
    // Last vector of its level.
    issue_command(make_cmd(pic_pkg::ACT_PEND, 2'd0, 1'b0, pic_pkg::TopLevel));
    issue_command(make_cmd(pic_pkg::ACT_PEND, 2'd0, 1'b0, 5'd0)); // tables empty
    issue_command(make_cmd(ActUndefined, 2'd3, 1'b1, pic_pkg::TopLevel));

    // Lines 0 and 1 share level 8, line 2 sits at level 4, line 3 at level 0.
    write_line_vectors(32'h0120_4647);
    // Loses to the processor priority and goes pending.
    issue_command(make_cmd(pic_pkg::ACT_LINE, 2'd0, 1'b1, pic_pkg::TopLevel));
    issue_command(make_cmd(pic_pkg::ACT_LINE, 2'd1, 1'b1, 5'd0)); // latched
    issue_command(make_cmd(pic_pkg::ACT_LINE, 2'd2, 1'b1, 5'd0)); // latch busy, pending
    issue_command(make_cmd(pic_pkg::ACT_LINE, 2'd3, 1'b0, 5'd0)); // deassertion
    issue_command(make_cmd(pic_pkg::ACT_LINE, 2'd3, 1'b1, 5'd0)); // level zero, pending
    // Latch not eligible, so it is kept.
    issue_command(make_cmd(pic_pkg::ACT_IMM, 2'd0, 1'b0, 5'd20));
    issue_command(make_cmd(pic_pkg::ACT_PEND, 2'd0, 1'b0, 5'd0));
    issue_command(make_cmd(pic_pkg::ACT_PEND, 2'd0, 1'b0, 5'd5));
    issue_command(make_cmd(pic_pkg::ACT_PEND, 2'd0, 1'b0, 5'd3));
    issue_command(make_cmd(pic_pkg::ACT_IMM, 2'd0, 1'b0, 5'd7));
    issue_command(make_cmd(pic_pkg::ACT_PEND, 2'd0, 1'b0, 5'd0)); // level zero never wins

    // Random part: each phase runs under its own line_vectors setting. The
    // sender works in bursts; about a third of the gaps are zero so that long
    // stretches of back-to-back transfers occur as well.
    for (int p = 0; p < RandomPhases; p++) begin
      case (p)
        0:       setting = 32'h0000_0000;
        1:       setting = 32'hffff_ffff;
        2:       setting = 32'h0701_0205;
        default: setting = random_vectors();
      endcase
      write_line_vectors(setting);
      sent = 0;
      while (sent < PhaseItems) begin
        burst = $urandom_range(1, 24);
        for (int k = 0; k < burst && sent < PhaseItems; k++) begin
          issue_command(random_command());
          sent = sent + 1;
        end
        pause(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
      end
    end

    wait_idle();
    repeat (4) @(posedge clk_i);
    drain <= 1'b1;
    repeat (2) @(posedge clk_i);

    $display("Covered %0d commands under %0d line_vectors settings plus the reset one.",
             commands_sent, settings_used);
    $display("Checked %0d results, %0d of them dispatched interrupts.", checked, dispatched);
    if (error_count == 0) begin
      $display("priority_interrupt_controller_top regression: pass");
    end else begin
      $display("priority_interrupt_controller_top regression: fail");
    end
    $finish;
  end

  // Watchdog: a run that hangs is ended and reported as a failure.
  initial begin : watchdog
    #2_000_000;
    $display("priority_interrupt_controller_top regression: fail");
    $finish;
  end

endmodule
